[rtl/ple_pkg.sv]
// Shared constants, codes and types of the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

   // list geometry
   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   // widths of the word fields on the channels
   localparam int OP_W    = 3;
   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;
   localparam int RD_W    = 32;
   localparam int COUNT_W = 7;

   // internal widths derived from the geometry
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // operation codes of a request word
   typedef enum logic [OP_W-1:0] {
      OP_READ     = 3'd0,
      OP_INS_TAIL = 3'd1,
      OP_INS_HEAD = 3'd2,
      OP_INS_POS  = 3'd3,
      OP_REM_HEAD = 3'd4,
      OP_REM_TAIL = 3'd5
   } op_type;

   // what the cell row does this cycle
   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2
   } shift_type;

   // control from the sequencer to the cell row
   typedef struct packed {
      shift_type             kind;
      logic [IDX_W-1:0]      slot;
      logic [DATA_WIDTH-1:0] word;
      logic [IDX_W-1:0]      rd_idx;
   } cell_cmd_type;

endpackage

[rtl/ple_if.sv]
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps

interface ple_req_if;
   logic                        valid;
   logic                        ready;
   logic [ple_pkg::OP_W-1:0]    op;
   logic [ple_pkg::POS_W-1:0]   pos;
   logic [ple_pkg::VALUE_W-1:0] value;

   modport source (output valid, output op, output pos, output value, input ready);
   modport sink   (input valid, input op, input pos, input value, output ready);
endinterface

interface ple_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        ok;
   logic [ple_pkg::RD_W-1:0]    read_value;
   logic [ple_pkg::COUNT_W-1:0] count;
   logic                        is_empty;
   logic                        is_full;

   modport source (output valid, output ok, output read_value, output count,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input ok, input read_value, input count,
                   input is_empty, input is_full, output ready);
endinterface

[rtl/positional_list_engine.sv]
// Top level of the positional list engine.
`timescale 1ns / 1ps
//
// Ordered list of up to CAPACITY data words held in a row of shifting cells.
// Request words arrive on req_port (op, pos, value) and each one produces
// exactly one response word on rsp_port (ok, read_value, count, is_empty,
// is_full), in order. Both channels move a word when valid and ready are
// high at a rising clock edge.
// A request taken on req_port is held in the request register and decoded
// from it; its response goes into the response register, which drives
// rsp_port.valid. Throughput: one word per cycle while responses are taken;
// the cell row does an insert, remove or indexed read from the held request.
// Stall: while a response waits, the held request stays in its register and
// req_port.ready drops only once that register is also full; when the
// response is taken, the held request moves in the same cycle.
// Reset (synchronous, active high) empties the list and both registers;
// cell contents are not cleared, and positions past the count are never read.
//
module positional_list_engine (
   input  logic        clock,
   input  logic        reset,
   ple_req_if.sink     req_port,
   ple_rsp_if.source   rsp_port
);

   ple_pkg::cell_cmd_type                cmd;
   logic [ple_pkg::DATA_WIDTH-1:0]       rd_data;

   // decode, count and response stage
   ple_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req     (req_port),
      .rsp     (rsp_port),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   // shifting data cells
   ple_cell_array u_cells (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

endmodule

[rtl/ple_cell_array.sv]
// Shifting row of data cells with one indexed read port.
`timescale 1ns / 1ps

module ple_cell_array (
   input  logic                              clock,
   input  ple_pkg::cell_cmd_type             cmd,
   output logic [ple_pkg::DATA_WIDTH-1:0]    rd_data
);

   localparam int CAP   = ple_pkg::CAPACITY;
   localparam int DW    = ple_pkg::DATA_WIDTH;
   localparam int IDX_W = ple_pkg::IDX_W;

   logic [DW-1:0] cell_ff [CAP];
   logic [DW-1:0] cell_in [CAP];

   // each cell picks its own value, the inserted word, or its upper or lower neighbor
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic [DW-1:0] from_lower;
      logic [DW-1:0] from_upper;

      if (i == 0) begin : g_first
         assign from_lower = cell_ff[i];
      end else begin : g_mid_lo
         assign from_lower = cell_ff[i-1];
      end

      if (i == CAP - 1) begin : g_last
         assign from_upper = cell_ff[i];
      end else begin : g_mid_hi
         assign from_upper = cell_ff[i+1];
      end

      always_comb begin
         cell_in[i] = cell_ff[i];
         case (cmd.kind)
            ple_pkg::CMD_INSERT: begin
               if (IDX_W'(i) == cmd.slot) begin
                  cell_in[i] = cmd.word;
               end else if (IDX_W'(i) > cmd.slot) begin
                  cell_in[i] = from_lower;
               end
            end
            ple_pkg::CMD_REMOVE: begin
               if (IDX_W'(i) >= cmd.slot) begin
                  cell_in[i] = from_upper;
               end
            end
            default: cell_in[i] = cell_ff[i];
         endcase
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // indexed read, registered by the response stage
   assign rd_data = cell_ff[cmd.rd_idx];

endmodule

[rtl/ple_ctrl.sv]
// Request register, operation decode, element count and response register.
`timescale 1ns / 1ps

module ple_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   ple_req_if.sink                        req,
   ple_rsp_if.source                      rsp,
   output ple_pkg::cell_cmd_type          cmd,
   input  logic [ple_pkg::DATA_WIDTH-1:0] rd_data
);

   localparam int DW      = ple_pkg::DATA_WIDTH;
   localparam int IDX_W   = ple_pkg::IDX_W;
   localparam int CNT_W   = ple_pkg::CNT_W;
   localparam int CMP_W   = ple_pkg::CMP_W;
   localparam int RD_W    = ple_pkg::RD_W;
   localparam int COUNT_W = ple_pkg::COUNT_W;

   // request stage
   logic                          s1_valid_ff, s1_valid_in;
   logic [ple_pkg::OP_W-1:0]      s1_op_ff;
   logic [ple_pkg::POS_W-1:0]     s1_pos_ff;
   logic [ple_pkg::VALUE_W-1:0]   s1_value_ff;

   // list state
   logic [CNT_W-1:0]              count_ff, count_in;

   // response stage
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_ok_ff;
   logic [RD_W-1:0]               rsp_rd_ff;
   logic [COUNT_W-1:0]            rsp_count_ff;
   logic                          rsp_empty_ff;
   logic                          rsp_full_ff;

   logic                          advance;
   logic                          take_req;
   logic                          op_ok;
   logic                          is_read;
   ple_pkg::shift_type            kind;
   logic [CMP_W-1:0]              slot_x;
   logic [CMP_W-1:0]              pos_x;
   logic [CMP_W-1:0]              cnt_x;
   logic                          full;
   logic                          empty;

   // 1-based position to cell index
   function automatic logic [IDX_W-1:0] slot_of_pos(input logic [CMP_W-1:0] p);
      logic [CMP_W-1:0] s;
      s = p - CMP_W'(1);
      return s[IDX_W-1:0];
   endfunction

   // handshake: the request word moves on when the response slot frees up
   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;
   assign take_req = req.valid && req.ready;

   always_comb begin
      if (take_req) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_op_ff    <= req.op;
         s1_pos_ff   <= req.pos;
         s1_value_ff <= req.value;
      end
   end

   // decode the held request against the current count
   assign pos_x = CMP_W'(s1_pos_ff);
   assign cnt_x = CMP_W'(count_ff);
   assign full  = (count_ff == CNT_W'(ple_pkg::CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      op_ok   = 1'b0;
      is_read = 1'b0;
      kind    = ple_pkg::CMD_HOLD;
      slot_x  = '0;
      case (ple_pkg::op_type'(s1_op_ff))
         ple_pkg::OP_READ: begin
            is_read = 1'b1;
            op_ok   = (pos_x != '0) && (pos_x <= cnt_x);
         end
         ple_pkg::OP_INS_TAIL: begin
            kind   = ple_pkg::CMD_INSERT;
            op_ok  = !full;
            slot_x = cnt_x;
         end
         ple_pkg::OP_INS_HEAD: begin
            kind  = ple_pkg::CMD_INSERT;
            op_ok = !full;
         end
         ple_pkg::OP_INS_POS: begin
            kind   = ple_pkg::CMD_INSERT;
            op_ok  = !full && (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
            slot_x = pos_x - CMP_W'(1);
         end
         ple_pkg::OP_REM_HEAD: begin
            kind  = ple_pkg::CMD_REMOVE;
            op_ok = !empty;
         end
         ple_pkg::OP_REM_TAIL: begin
            kind   = ple_pkg::CMD_REMOVE;
            op_ok  = !empty;
            slot_x = cnt_x - CMP_W'(1);
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   // cell row command; only a successful word that moves on changes state
   always_comb begin
      cmd.kind   = (advance && op_ok) ? kind : ple_pkg::CMD_HOLD;
      cmd.slot   = slot_x[IDX_W-1:0];
      cmd.word   = DW'(s1_value_ff);
      cmd.rd_idx = slot_of_pos(pos_x);
   end

   // count after the operation
   always_comb begin
      case (cmd.kind)
         ple_pkg::CMD_INSERT: count_in = count_ff + CNT_W'(1);
         ple_pkg::CMD_REMOVE: count_in = count_ff - CNT_W'(1);
         default:             count_in = count_ff;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ok_ff    <= op_ok;
         rsp_rd_ff    <= (is_read && op_ok) ? RD_W'(rd_data) : '0;
         rsp_count_ff <= COUNT_W'(count_in);
         rsp_empty_ff <= (count_in == '0);
         rsp_full_ff  <= (count_in == CNT_W'(ple_pkg::CAPACITY));
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.ok         = rsp_ok_ff;
   assign rsp.read_value = rsp_rd_ff;
   assign rsp.count      = rsp_count_ff;
   assign rsp.is_empty   = rsp_empty_ff;
   assign rsp.is_full    = rsp_full_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ple_pkg::CAPACITY))
      else $error("element count above capacity");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == COUNT_W'(count_ff)))
      else $error("pending response count differs from list count");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_rd_ff == '0))
      else $error("failed response carries a read word");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.kind == ple_pkg::CMD_INSERT) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("insert did not raise the count by one");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> $stable(count_ff))
      else $error("list changed while the response was stalled");

endmodule
